/* rtl/tilt_compensated_heading_defines.svh */
// ----------------------------------------------------------------------------
// Tilt-compensated heading: assertion macros
// Shared wrappers for the concurrent checks of the heading block.
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_HEADING_DEFINES_SVH
`define TILT_COMPENSATED_HEADING_DEFINES_SVH

// check on every edge outside reset
`define TCH_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define TCH_ASSERT(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tch_pkg.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading: package
// Word types, widths and the arctangent table shared by the heading block.
// ----------------------------------------------------------------------------
package tch_pkg;

	localparam int unsigned ANGLE_BITS_DEF    = 16;
	localparam int unsigned CORDIC_STAGES_DEF = 18;
	localparam int unsigned ATAN_LEN          = 28;
	localparam int unsigned AXIS_W            = 64;
	localparam int unsigned TURN_W            = 32;

	localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [TURN_W-1:0] HALF_TURN    = 32'h8000_0000;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [TURN_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

	typedef struct packed {
		logic signed [15:0] grav_x;
		logic signed [15:0] grav_y;
		logic signed [15:0] grav_z;
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
		logic signed [15:0] mag_z;
	} sample_t;

	typedef struct packed {
		logic        [15:0] heading;
		logic signed [15:0] inclination;
		logic        [15:0] dip_angle;
		logic               degenerate;
	} result_t;

endpackage

/* rtl/tch_stream_if.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading: stream interface
// Valid/ready channel carrying one word per accepted handshake.
// ----------------------------------------------------------------------------
interface tch_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/tilt_compensated_heading.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading
// Takes one gravity and one magnetic vector per word and returns heading,
// inclination and dip angle in binary fractions of a turn. One word is
// accepted every clock cycle while the result channel is not stalled; the
// results leave in order through the product stages, the 32-stage square
// root and the CORDIC chain. Back-pressure on the result channel holds
// the whole pipeline, so sample ready follows result ready while a result
// waits. A zero-length input vector sets degenerate and zeroes the angles.
// ----------------------------------------------------------------------------
module tilt_compensated_heading #(
	parameter int unsigned ANGLE_BITS    = tch_pkg::ANGLE_BITS_DEF,
	parameter int unsigned CORDIC_STAGES = tch_pkg::CORDIC_STAGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tch_stream_if.sink   sample,
	tch_stream_if.source result
);
	localparam int unsigned AW     = tch_pkg::AXIS_W;
	localparam int unsigned TW     = tch_pkg::TURN_W;
	localparam int unsigned SQ_LAT = AW / 2;
	localparam int unsigned CO_LAT = CORDIC_STAGES + 4;
	localparam int unsigned LAT    = 39 + CO_LAT;
	localparam logic [TW:0] U_MASK = (33'd1 << ANGLE_BITS) - 33'd1;

	typedef struct packed {
		logic signed [32:0] d;
		logic signed [49:0] cp;
		logic signed [15:0] gx;
		logic        [4:0]  kg;
		logic signed [32:0] p;
		logic        [4:0]  kd;
		logic               deg;
	} side_t;

	logic en;
	logic v_q [LAT];

	// stage 1: products
	logic signed [31:0] sqg_s1 [3];
	logic signed [31:0] sqm_s1 [3];
	logic signed [31:0] dot_s1 [3];
	logic signed [31:0] crs_s1 [6];
	logic signed [15:0] gx_s1, mx_s1;
	// stage 2: sums
	logic        [31:0] gg_s2, mm_s2, hh_s2;
	logic signed [32:0] p_s2, cx_s2, cy_s2, cz_s2;
	logic signed [15:0] gx_s2, mx_s2;
	// stage 3: wide products
	logic signed [48:0] gmx_s3, pgx_s3;
	logic        [63:0] cx2_s3, cy2_s3, cz2_s3, gmm_s3;
	logic        [31:0] gg_s3, hh_s3;
	logic signed [32:0] p_s3, d_s3;
	logic signed [15:0] gx_s3;
	logic               deg_s3;
	// stage 4: combine, normalize
	logic signed [49:0] cp_s4;
	logic        [63:0] q_s4;
	logic        [4:0]  kg_s4, kd_s4;
	logic        [31:0] gg_s4, hh_s4;
	logic signed [32:0] p_s4, d_s4;
	logic signed [15:0] gx_s4;
	logic               deg_s4;
	// stage 5: radicands
	logic        [63:0] radh_s5, radi_s5, radd_s5;
	side_t              side_s5;
	side_t              side_q [SQ_LAT];
	side_t              sd;
	logic        [31:0] sg, ri, rd;
	logic signed [65:0] dsg;
	// stage 6: atan2 operands
	logic signed [AW-1:0] yh_s6, xh_s6, yi_s6, xi_s6, yd_s6, xd_s6;
	logic                 deg_s6;
	logic                 deg_q [CO_LAT];
	logic        [TW-1:0] ah, ai, ad;
	logic        [15:0]   heading_q, dip_q;
	logic signed [15:0]   incl_q;
	logic                 degen_q;

	function automatic logic [4:0] norm_shift(input logic [63:0] v);
		logic [4:0] k;
		k = '0;
		for (int j = 0; j < 30; j++) begin
			if ((v >> (60 - 2 * j)) == 64'd0) k = k + 5'd1;
		end
		return k;
	endfunction

	function automatic logic [15:0] round_turn_u(input logic [TW-1:0] a);
		logic [TW:0] t;
		t = ({1'b0, a} + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
		t = t & U_MASK;
		return t[15:0];
	endfunction

	function automatic logic [15:0] round_turn_s(input logic [TW-1:0] a);
		logic signed [TW+1:0] v;
		v = -$signed({{2{a[TW-1]}}, a}) + $signed(34'd1 << (31 - ANGLE_BITS));
		v = v >>> (32 - ANGLE_BITS);
		return v[15:0];
	endfunction

	assign en           = !v_q[LAT-1] || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) v_q[k] <= 1'b0;
		end else if (en) begin
			v_q[0] <= sample.valid;
			for (int k = 1; k < LAT; k++) v_q[k] <= v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqg_s1[0] <= sample.data.grav_x * sample.data.grav_x;
			sqg_s1[1] <= sample.data.grav_y * sample.data.grav_y;
			sqg_s1[2] <= sample.data.grav_z * sample.data.grav_z;
			sqm_s1[0] <= sample.data.mag_x * sample.data.mag_x;
			sqm_s1[1] <= sample.data.mag_y * sample.data.mag_y;
			sqm_s1[2] <= sample.data.mag_z * sample.data.mag_z;
			dot_s1[0] <= sample.data.grav_x * sample.data.mag_x;
			dot_s1[1] <= sample.data.grav_y * sample.data.mag_y;
			dot_s1[2] <= sample.data.grav_z * sample.data.mag_z;
			crs_s1[0] <= sample.data.mag_y * sample.data.grav_z;
			crs_s1[1] <= sample.data.mag_z * sample.data.grav_y;
			crs_s1[2] <= sample.data.mag_z * sample.data.grav_x;
			crs_s1[3] <= sample.data.mag_x * sample.data.grav_z;
			crs_s1[4] <= sample.data.mag_x * sample.data.grav_y;
			crs_s1[5] <= sample.data.mag_y * sample.data.grav_x;
			gx_s1     <= sample.data.grav_x;
			mx_s1     <= sample.data.mag_x;

			gg_s2 <= $unsigned(sqg_s1[0]) + $unsigned(sqg_s1[1]) + $unsigned(sqg_s1[2]);
			mm_s2 <= $unsigned(sqm_s1[0]) + $unsigned(sqm_s1[1]) + $unsigned(sqm_s1[2]);
			hh_s2 <= $unsigned(sqg_s1[1]) + $unsigned(sqg_s1[2]);
			p_s2  <= 33'(dot_s1[0]) + 33'(dot_s1[1]) + 33'(dot_s1[2]);
			cx_s2 <= 33'(crs_s1[0]) - 33'(crs_s1[1]);
			cy_s2 <= 33'(crs_s1[2]) - 33'(crs_s1[3]);
			cz_s2 <= 33'(crs_s1[4]) - 33'(crs_s1[5]);
			gx_s2 <= gx_s1;
			mx_s2 <= mx_s1;

			gmx_s3 <= $signed({1'b0, gg_s2}) * mx_s2;
			pgx_s3 <= p_s2 * gx_s2;
			cx2_s3 <= cx_s2 * cx_s2;
			cy2_s3 <= cy_s2 * cy_s2;
			cz2_s3 <= cz_s2 * cz_s2;
			gmm_s3 <= gg_s2 * mm_s2;
			gg_s3  <= gg_s2;
			hh_s3  <= hh_s2;
			p_s3   <= p_s2;
			d_s3   <= cx_s2;
			gx_s3  <= gx_s2;
			deg_s3 <= (gg_s2 == '0) || (mm_s2 == '0);

			cp_s4  <= 50'(gmx_s3) - 50'(pgx_s3);
			q_s4   <= cx2_s3 + cy2_s3 + cz2_s3;
			kg_s4  <= norm_shift({32'd0, gg_s3});
			kd_s4  <= norm_shift(gmm_s3);
			gg_s4  <= gg_s3;
			hh_s4  <= hh_s3;
			p_s4   <= p_s3;
			d_s4   <= d_s3;
			gx_s4  <= gx_s3;
			deg_s4 <= deg_s3;

			radh_s5     <= {2'b00, gg_s4, 30'd0};
			radi_s5     <= {32'd0, hh_s4} << {kg_s4, 1'b0};
			radd_s5     <= q_s4 << {kd_s4, 1'b0};
			side_s5.d   <= d_s4;
			side_s5.cp  <= cp_s4;
			side_s5.gx  <= gx_s4;
			side_s5.kg  <= kg_s4;
			side_s5.p   <= p_s4;
			side_s5.kd  <= kd_s4;
			side_s5.deg <= deg_s4;

			side_q[0] <= side_s5;
			for (int k = 1; k < SQ_LAT; k++) side_q[k] <= side_q[k-1];
		end
	end

	tch_isqrt #(.RAD_W(AW)) u_sqrt_h (.clk(clk), .en(en), .rad(radh_s5), .root(sg));
	tch_isqrt #(.RAD_W(AW)) u_sqrt_i (.clk(clk), .en(en), .rad(radi_s5), .root(ri));
	tch_isqrt #(.RAD_W(AW)) u_sqrt_d (.clk(clk), .en(en), .rad(radd_s5), .root(rd));

	assign sd  = side_q[SQ_LAT-1];
	assign dsg = sd.d * $signed({1'b0, sg});

	always_ff @(posedge clk) begin
		if (en) begin
			yh_s6  <= -dsg[AW-1:0];
			xh_s6  <= AW'(sd.cp) <<< 15;
			yi_s6  <= AW'(sd.gx) <<< sd.kg;
			xi_s6  <= AW'(ri);
			yd_s6  <= AW'(rd);
			xd_s6  <= AW'(sd.p) <<< sd.kd;
			deg_s6 <= sd.deg;

			deg_q[0] <= deg_s6;
			for (int k = 1; k < CO_LAT; k++) deg_q[k] <= deg_q[k-1];
		end
	end

	tch_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_h (
		.clk(clk), .en(en), .y(yh_s6), .x(xh_s6), .angle(ah)
	);
	tch_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_i (
		.clk(clk), .en(en), .y(yi_s6), .x(xi_s6), .angle(ai)
	);
	tch_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_d (
		.clk(clk), .en(en), .y(yd_s6), .x(xd_s6), .angle(ad)
	);

	// zero the angles of a degenerate word
	always_ff @(posedge clk) begin
		if (en) begin
			degen_q   <= deg_q[CO_LAT-1];
			heading_q <= deg_q[CO_LAT-1] ? '0 : round_turn_u(ah);
			incl_q    <= deg_q[CO_LAT-1] ? '0 : $signed(round_turn_s(ai));
			dip_q     <= deg_q[CO_LAT-1] ? '0 : round_turn_u(ad);
		end
	end

	assign result.valid            = v_q[LAT-1];
	assign result.data.heading     = heading_q;
	assign result.data.inclination = incl_q;
	assign result.data.dip_angle   = dip_q;
	assign result.data.degenerate  = degen_q;
endmodule

/* rtl/tch_isqrt.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading: pipelined integer square root
// Floor square root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module tch_isqrt #(
	parameter int unsigned RAD_W = tch_pkg::AXIS_W
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [RAD_W-1:0]     rad,
	output logic [RAD_W/2-1:0]   root
);
	localparam int unsigned ROOT_W = RAD_W / 2;
	localparam int unsigned REM_W  = ROOT_W + 3;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} step_t;

	logic [REM_W-1:0]  rem_q  [ROOT_W];
	logic [ROOT_W-1:0] root_q [ROOT_W];
	logic [RAD_W-1:0]  rad_q  [ROOT_W];
	step_t             step_d [ROOT_W];

	function automatic step_t sqrt_step(input logic [REM_W-1:0] rem_in,
			input logic [ROOT_W-1:0] root_in, input logic [1:0] pair);
		logic [REM_W-1:0] acc;
		logic [REM_W-1:0] trial;
		step_t            res;
		acc   = {rem_in[REM_W-3:0], pair};
		trial = REM_W'({root_in, 2'b01});
		if (acc >= trial) begin
			res.rem  = acc - trial;
			res.root = {root_in[ROOT_W-2:0], 1'b1};
		end else begin
			res.rem  = acc;
			res.root = {root_in[ROOT_W-2:0], 1'b0};
		end
		return res;
	endfunction

	always_comb begin
		step_d[0] = sqrt_step('0, '0, rad[RAD_W-1 -: 2]);
		for (int j = 1; j < ROOT_W; j++) begin
			step_d[j] = sqrt_step(rem_q[j-1], root_q[j-1],
				rad_q[j-1][2*(ROOT_W-1-j)+1 -: 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q[0] <= rad;
			for (int j = 0; j < ROOT_W; j++) begin
				rem_q[j]  <= step_d[j].rem;
				root_q[j] <= step_d[j].root;
			end
			for (int j = 1; j < ROOT_W; j++) begin
				rad_q[j] <= rad_q[j-1];
			end
		end
	end

	assign root = root_q[ROOT_W-1];
endmodule

/* rtl/tch_cordic.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading: pipelined CORDIC arctangent
// Vectoring atan2 over wide operands, angle as a 32-bit fraction of a turn.
// ----------------------------------------------------------------------------
module tch_cordic #(
	parameter int unsigned STAGES = tch_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [tch_pkg::AXIS_W-1:0]   y,
	input  logic signed [tch_pkg::AXIS_W-1:0]   x,
	output logic        [tch_pkg::TURN_W-1:0]   angle
);
	localparam int unsigned AW   = tch_pkg::AXIS_W;
	localparam int unsigned TW   = tch_pkg::TURN_W;
	localparam int unsigned VW   = 34;
	localparam int unsigned ZW   = 34;
	localparam int unsigned NORM = 30;
	localparam int unsigned SW   = 6;
	localparam int unsigned SGN  = STAGES + 3;

	logic [AW-1:0]        ax_q, ay_q, big_q;
	logic [AW-1:0]        ax2_q, ay2_q;
	logic [SW-1:0]        shamt_q;
	logic                 xn_q [SGN];
	logic                 yn_q [SGN];
	logic signed [VW-1:0] cx_q [STAGES+1];
	logic signed [VW-1:0] cy_q [STAGES+1];
	logic signed [ZW-1:0] z_q  [STAGES+1];
	logic signed [VW-1:0] cx_d [STAGES];
	logic signed [VW-1:0] cy_d [STAGES];
	logic signed [ZW-1:0] z_d  [STAGES];
	logic [SW-1:0]        shamt_d;
	logic [AW-1:0]        shx, shy;
	logic [TW-1:0]        mag_a;
	logic [TW-1:0]        angle_d;
	logic signed [ZW-1:0] zf;

	always_comb begin
		shamt_d = '0;
		for (int j = NORM; j < AW; j++) begin
			if ((big_q >> j) != '0) shamt_d = shamt_d + SW'(1);
		end
	end

	assign shx = ax2_q >> shamt_q;
	assign shy = ay2_q >> shamt_q;

	always_comb begin
		for (int j = 0; j < STAGES; j++) begin
			if (cy_q[j] > 0) begin
				cx_d[j] = cx_q[j] + (cy_q[j] >>> j);
				cy_d[j] = cy_q[j] - (cx_q[j] >>> j);
				z_d[j]  = z_q[j] + $signed({2'b00, tch_pkg::ATAN_TURNS[j]});
			end else if (cy_q[j] < 0) begin
				cx_d[j] = cx_q[j] + ((-cy_q[j]) >>> j);
				cy_d[j] = cy_q[j] + (cx_q[j] >>> j);
				z_d[j]  = z_q[j] - $signed({2'b00, tch_pkg::ATAN_TURNS[j]});
			end else begin
				cx_d[j] = cx_q[j];
				cy_d[j] = cy_q[j];
				z_d[j]  = z_q[j];
			end
		end
	end

	assign zf = z_q[STAGES];

	always_comb begin
		if (zf < 0) begin
			mag_a = '0;
		end else if (zf > $signed({2'b00, tch_pkg::QUARTER_TURN})) begin
			mag_a = tch_pkg::QUARTER_TURN;
		end else begin
			mag_a = zf[TW-1:0];
		end
		if (!xn_q[SGN-1]) begin
			angle_d = yn_q[SGN-1] ? TW'(-mag_a) : mag_a;
		end else begin
			angle_d = yn_q[SGN-1] ? tch_pkg::HALF_TURN + mag_a : tch_pkg::HALF_TURN - mag_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ay_q    <= y[AW-1] ? AW'(-y) : AW'(y);
			ax_q    <= x[AW-1] ? AW'(-x) : AW'(x);
			big_q   <= ((y[AW-1] ? AW'(-y) : AW'(y)) > (x[AW-1] ? AW'(-x) : AW'(x))) ?
				(y[AW-1] ? AW'(-y) : AW'(y)) : (x[AW-1] ? AW'(-x) : AW'(x));
			xn_q[0] <= x[AW-1];
			yn_q[0] <= y[AW-1];

			ax2_q   <= ax_q;
			ay2_q   <= ay_q;
			shamt_q <= shamt_d;

			cx_q[0] <= VW'(shx[NORM-1:0]);
			cy_q[0] <= VW'(shy[NORM-1:0]);
			z_q[0]  <= '0;

			for (int j = 1; j < SGN; j++) begin
				xn_q[j] <= xn_q[j-1];
				yn_q[j] <= yn_q[j-1];
			end
			for (int j = 0; j < STAGES; j++) begin
				cx_q[j+1] <= cx_d[j];
				cy_q[j+1] <= cy_d[j];
				z_q[j+1]  <= z_d[j];
			end

			angle <= angle_d;
		end
	end
endmodule

/* rtl/tch_checker.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading: port checker
// Watches the sample and result channels of the heading block.
// ----------------------------------------------------------------------------
`include "tilt_compensated_heading_defines.svh"

module tch_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input tch_pkg::result_t out_data
);
	`TCH_ASSERT_RST(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")
	`TCH_ASSERT_RST(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_data), "result word changed while stalled")
	`TCH_ASSERT_RST(a_degen_zero, clk, arst_n, out_valid && out_data.degenerate |-> out_data.heading == '0 && out_data.inclination == '0 && out_data.dip_angle == '0, "degenerate word carries nonzero angle")
	`TCH_ASSERT(a_ready_flow, clk, arst_n && !in_valid |-> in_ready == (!out_valid || out_ready), "sample ready does not follow result stall")
endmodule

bind tilt_compensated_heading tch_checker u_tch_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (sample.valid),
	.in_ready (sample.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_data (result.data)
);

/* sim/tilt_compensated_heading_tb.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading testbench
// Drives gravity/magnetic sample words through the heading block with random
// idling on both channels and one long result hold-off, predicts heading,
// inclination and dip angle with an integer CORDIC model of its own, and
// compares every result word field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tilt_compensated_heading_tb;
	import tch_pkg::*;

	localparam int unsigned STAGES = CORDIC_STAGES_DEF;
	localparam int unsigned ABITS  = ANGLE_BITS_DEF;
	localparam int unsigned LATENCY = 43 + STAGES;
	localparam int unsigned N_RANDOM = 980;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tch_stream_if #(.word_t(sample_t)) sample ();
	tch_stream_if #(.word_t(result_t)) result ();

	tilt_compensated_heading dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sample_t pending_samples[$];
	result_t expected_angles[$];
	int unsigned mismatches = 0;
	bit stim_done = 1'b0;
	bit quiet_tail = 1'b0;
	bit hold_result = 1'b0;

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic int unsigned even_shift(logic [63:0] v);
		int unsigned k;
		k = 0;
		while (k < 30 && (v >> (60 - 2 * k)) == 0) k++;
		return k;
	endfunction

	function automatic logic [63:0] abs64(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic logic [31:0] vector_angle(longint y, longint x);
		logic [63:0] ay, ax, big;
		longint cx, cy, z, nx;
		logic [31:0] a;
		ay = abs64(y);
		ax = abs64(x);
		big = ay > ax ? ay : ax;
		z = 0;
		while (big >= 64'(QUARTER_TURN)) begin
			big = big >> 1;
			ay = ay >> 1;
			ax = ax >> 1;
		end
		cx = longint'(ax);
		cy = longint'(ay);
		for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
			if (cy > 0) begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				cx = nx;
				z += longint'(ATAN_TURNS[i]);
			end else if (cy < 0) begin
				nx = cx + longint'(64'(-cy) >> i);
				cy = cy + (cx >>> i);
				cx = nx;
				z -= longint'(ATAN_TURNS[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(QUARTER_TURN)) z = longint'(QUARTER_TURN);
		a = z[31:0];
		if (x >= 0) return y >= 0 ? a : 32'd0 - a;
		return y >= 0 ? HALF_TURN - a : HALF_TURN + a;
	endfunction

	function automatic logic [15:0] turn_round(logic [31:0] a);
		logic [63:0] v;
		v = (64'(a) + (64'd1 << (31 - ABITS))) >> (32 - ABITS);
		return v[15:0];
	endfunction

	function automatic result_t predict_angles(sample_t s);
		result_t r;
		longint gx, gy, gz, mx, my, mz, g2, m2, p, d, cp, cx, cy, cz, sv, off, rs;
		logic [63:0] sg, h, q, gm, rt;
		int unsigned k;
		logic [31:0] a;
		gx = s.grav_x; gy = s.grav_y; gz = s.grav_z;
		mx = s.mag_x; my = s.mag_y; mz = s.mag_z;
		g2 = gx * gx + gy * gy + gz * gz;
		m2 = mx * mx + my * my + mz * mz;
		r = '0;
		if (g2 == 0 || m2 == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		p = gx * mx + gy * my + gz * mz;
		d = my * gz - mz * gy;
		cp = g2 * mx - p * gx;
		sg = int_sqrt(64'(g2) << 30);
		r.heading = turn_round(vector_angle(-d * longint'(sg), cp * 32768));
		h = 64'(gy * gy + gz * gz);
		k = even_shift(64'(g2));
		rt = int_sqrt(h << (2 * k));
		a = vector_angle(gx * (longint'(1) << k), longint'(rt));
		sv = a < HALF_TURN ? longint'(a) : longint'(a) - (longint'(1) << 32);
		off = longint'(1) << 33;
		rs = ((-sv + (longint'(1) << (31 - ABITS)) + off) >>> (32 - ABITS))
			- (off >>> (32 - ABITS));
		r.inclination = rs[15:0];
		cx = my * gz - mz * gy;
		cy = mz * gx - mx * gz;
		cz = mx * gy - my * gx;
		q = 64'(cx * cx) + 64'(cy * cy) + 64'(cz * cz);
		gm = 64'(g2) * 64'(m2);
		k = even_shift(gm);
		rt = int_sqrt(q << (2 * k));
		r.dip_angle = turn_round(vector_angle(longint'(rt), p * (longint'(1) << k)));
		return r;
	endfunction

	function automatic logic [15:0] pick_component();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t make_sample(int gx, int gy, int gz, int mx, int my, int mz);
		sample_t s;
		s.grav_x = 16'(gx); s.grav_y = 16'(gy); s.grav_z = 16'(gz);
		s.mag_x = 16'(mx); s.mag_y = 16'(my); s.mag_z = 16'(mz);
		return s;
	endfunction

	// driver
	int unsigned send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
			sample.data <= '0;
		end else begin
			if (sample.valid && sample.ready) begin
				expected_angles.push_back(predict_angles(sample.data));
			end
			if (!sample.valid || sample.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					sample.valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					sample.valid <= 1'b1;
					sample.data <= pending_samples.pop_front();
					if (!quiet_tail && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 14);
				end else begin
					sample.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int unsigned recv_gap = 0;
	result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_angles.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %p", result.data);
				end else begin
					want = expected_angles.pop_front();
					if (result.data.heading !== want.heading
						|| result.data.inclination !== want.inclination
						|| result.data.dip_angle !== want.dip_angle
						|| result.data.degenerate !== want.degenerate) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", want, result.data);
					end
				end
			end
			if (hold_result) begin
				result.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
				if (!quiet_tail && $urandom_range(0, 9) == 0)
					recv_gap <= $urandom_range(1, 14);
			end
		end
	end

	initial begin
		sample_t s;
		sample.valid = 1'b0;
		sample.data = '0;
		result.ready = 1'b0;
		pending_samples.push_back(make_sample(0, 0, 0, 100, 200, 300));
		pending_samples.push_back(make_sample(100, 200, 300, 0, 0, 0));
		pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0));
		pending_samples.push_back(make_sample(0, 0, 1000, 0, 0, 2000));
		pending_samples.push_back(make_sample(0, 0, 1000, 0, 0, -2000));
		pending_samples.push_back(make_sample(300, -400, 500, -600, 800, -1000));
		pending_samples.push_back(make_sample(32767, 0, 0, 0, 32767, 0));
		pending_samples.push_back(make_sample(-32768, 0, 0, 0, -32768, 0));
		pending_samples.push_back(make_sample(0, 0, 16384, 16384, 0, 0));
		pending_samples.push_back(make_sample(0, 0, 16384, 0, 16384, 0));
		pending_samples.push_back(make_sample(0, 0, 16384, -16384, 0, 0));
		pending_samples.push_back(make_sample(0, 0, 16384, 0, -16384, 0));
		pending_samples.push_back(make_sample(0, 0, 16384, 16384, -1, 0));
		pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
		pending_samples.push_back(make_sample(32767, 32767, 32767, -32768, -32768, -32768));
		pending_samples.push_back(make_sample(-32768, 32767, -32768, 32767, -32768, 32767));
		pending_samples.push_back(make_sample(1, 0, 0, 0, 1, 0));
		pending_samples.push_back(make_sample(-1, 1, 0, 1, 1, -1));
		pending_samples.push_back(make_sample(5, 0, 0, 0, 0, -7));
		pending_samples.push_back(make_sample(-5, 0, 0, 32767, 0, 0));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			for (int f = 0; f < 6; f++) s[f*16 +: 16] = pick_component();
			if ($urandom_range(0, 29) == 0) begin
				if ($urandom_range(0, 1)) s[95:48] = '0;
				else s[47:0] = '0;
			end
			pending_samples.push_back(s);
			if (i == 400) begin
				while (pending_samples.size() > 0) @(posedge clk);
				// hold off the result side until the pipeline backs up
				hold_result = 1'b1;
				for (int j = 0; j < 150; j++) begin
					for (int f = 0; f < 6; f++) s[f*16 +: 16] = pick_component();
					pending_samples.push_back(s);
				end
				repeat (250) @(posedge clk);
				hold_result = 1'b0;
			end
			if (i == N_RANDOM - 150) begin
				while (pending_samples.size() > 0) @(posedge clk);
				quiet_tail = 1'b1;
			end
		end
		while (pending_samples.size() > 0 || sample.valid) @(posedge clk);
		while (expected_angles.size() > 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && expected_angles.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tch_pkg.sv
rtl/tch_stream_if.sv
rtl/tch_isqrt.sv
rtl/tch_cordic.sv
rtl/tilt_compensated_heading.sv
rtl/tch_checker.sv
sim/tilt_compensated_heading_tb.sv
